// ===== design/rc4kg_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4kg_pkg
// Shared constants, codes and control types of the RC4 keystream generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4kg_pkg;

	localparam int MAX_KEY_BYTES = 256;
	localparam int KEY_AW        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int PERM_SIZE     = 256;

	// item actions
	localparam logic [1:0] ACT_LOAD     = 2'd0;
	localparam logic [1:0] ACT_SCHEDULE = 2'd1;
	localparam logic [1:0] ACT_GENERATE = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_SCHEDULED = 2'd0;
	localparam logic [1:0] KIND_BYTE      = 2'd1;
	localparam logic [1:0] KIND_UNKEYED   = 2'd2;

	localparam logic [8:0] KEY_LENGTH_RESET = 9'd16;

	typedef enum logic [1:0] {
		MEM_NONE,
		MEM_RD,
		MEM_WR
	} mem_op_t;

	typedef enum logic [2:0] {
		ADDR_X,
		ADDR_KSA,
		ADDR_J,
		ADDR_I_INC,
		ADDR_J_SUM,
		ADDR_AB,
		ADDR_I
	} addr_sel_t;

	typedef enum logic [1:0] {
		WD_X,
		WD_SRD,
		WD_SA
	} wd_sel_t;

	// one datapath control word
	typedef struct packed {
		mem_op_t    mem_op;
		addr_sel_t  addr_sel;
		wd_sel_t    wd_sel;
		logic       clr_idx;
		logic       x_inc;
		logic       k_inc;
		logic       i_ld;
		logic       j_ld;
		logic       sa_ld;
		logic       sb_ld;
		logic       set_keyed;
		logic       emit;
		logic [1:0] kind;
	} dp_ctl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic keyed;
		logic x_last;
	} dp_status_t;

	// clamp the key length register to 1..MAX_KEY_BYTES
	function automatic logic [8:0] eff_key_len(input logic [8:0] len);
		logic [8:0] n;
		begin
			n = len;
			if (n == 9'd0) begin
				n = 9'd1;
			end
			if (n > 9'(MAX_KEY_BYTES)) begin
				n = 9'(MAX_KEY_BYTES);
			end
			return n;
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/rc4kg_seq.sv =====
// ----------------------------------------------------------------------------
// rc4kg_seq
// Microcode sequencer: step counter, control word ROM and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4kg_seq
	import rc4kg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] action,
	input  wire dp_status_t status,
	output dp_ctl_t         ctl,
	output logic            busy
);

	localparam int STEP_W = 4;

	localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] S_SINIT = 4'd1;
	localparam logic [STEP_W-1:0] S_INIT  = 4'd2;
	localparam logic [STEP_W-1:0] S_KSA1  = 4'd3;
	localparam logic [STEP_W-1:0] S_KSA2  = 4'd4;
	localparam logic [STEP_W-1:0] S_KSA3  = 4'd5;
	localparam logic [STEP_W-1:0] S_KSA4  = 4'd6;
	localparam logic [STEP_W-1:0] S_KFIN  = 4'd7;
	localparam logic [STEP_W-1:0] S_GEN1  = 4'd8;
	localparam logic [STEP_W-1:0] S_GEN2  = 4'd9;
	localparam logic [STEP_W-1:0] S_GEN3  = 4'd10;
	localparam logic [STEP_W-1:0] S_GEN4  = 4'd11;
	localparam logic [STEP_W-1:0] S_GEN5  = 4'd12;
	localparam logic [STEP_W-1:0] S_GEN6  = 4'd13;
	localparam logic [STEP_W-1:0] S_UNK   = 4'd14;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_GOTO,
		COND_X_LOOP,
		COND_DISPATCH
	} cond_t;

	typedef struct packed {
		dp_ctl_t           dp;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} seq_word_t;

	function automatic seq_word_t rom(input logic [STEP_W-1:0] s);
		seq_word_t w;
		begin
			w = '0;
			case (s)
				S_IDLE: begin
					w.cond = COND_DISPATCH;
				end
				S_SINIT: begin
					w.dp.clr_idx = 1'b1;
				end
				S_INIT: begin
					// identity fill, x wraps back to zero after the last entry
					w.dp.mem_op   = MEM_WR;
					w.dp.addr_sel = ADDR_X;
					w.dp.wd_sel   = WD_X;
					w.dp.x_inc    = 1'b1;
					w.cond        = COND_X_LOOP;
					w.target      = S_INIT;
				end
				S_KSA1: begin
					w.dp.mem_op   = MEM_RD;
					w.dp.addr_sel = ADDR_X;
				end
				S_KSA2: begin
					w.dp.mem_op   = MEM_RD;
					w.dp.addr_sel = ADDR_KSA;
					w.dp.j_ld     = 1'b1;
					w.dp.sa_ld    = 1'b1;
				end
				S_KSA3: begin
					w.dp.mem_op   = MEM_WR;
					w.dp.addr_sel = ADDR_X;
					w.dp.wd_sel   = WD_SRD;
				end
				S_KSA4: begin
					w.dp.mem_op   = MEM_WR;
					w.dp.addr_sel = ADDR_J;
					w.dp.wd_sel   = WD_SA;
					w.dp.x_inc    = 1'b1;
					w.dp.k_inc    = 1'b1;
					w.cond        = COND_X_LOOP;
					w.target      = S_KSA1;
				end
				S_KFIN: begin
					w.dp.clr_idx   = 1'b1;
					w.dp.set_keyed = 1'b1;
					w.dp.emit      = 1'b1;
					w.dp.kind      = KIND_SCHEDULED;
					w.cond         = COND_GOTO;
					w.target       = S_IDLE;
				end
				S_GEN1: begin
					w.dp.mem_op   = MEM_RD;
					w.dp.addr_sel = ADDR_I_INC;
					w.dp.i_ld     = 1'b1;
				end
				S_GEN2: begin
					w.dp.mem_op   = MEM_RD;
					w.dp.addr_sel = ADDR_J_SUM;
					w.dp.j_ld     = 1'b1;
					w.dp.sa_ld    = 1'b1;
				end
				S_GEN3: begin
					w.dp.mem_op   = MEM_WR;
					w.dp.addr_sel = ADDR_I;
					w.dp.wd_sel   = WD_SRD;
					w.dp.sb_ld    = 1'b1;
				end
				S_GEN4: begin
					w.dp.mem_op   = MEM_WR;
					w.dp.addr_sel = ADDR_J;
					w.dp.wd_sel   = WD_SA;
				end
				S_GEN5: begin
					w.dp.mem_op   = MEM_RD;
					w.dp.addr_sel = ADDR_AB;
				end
				S_GEN6: begin
					w.dp.emit = 1'b1;
					w.dp.kind = KIND_BYTE;
					w.cond    = COND_GOTO;
					w.target  = S_IDLE;
				end
				S_UNK: begin
					w.dp.emit = 1'b1;
					w.dp.kind = KIND_UNKEYED;
					w.cond    = COND_GOTO;
					w.target  = S_IDLE;
				end
				default: begin
					w.cond   = COND_GOTO;
					w.target = S_IDLE;
				end
			endcase
			return w;
		end
	endfunction

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	seq_word_t         word;

	assign word = rom(step_q);
	assign ctl  = word.dp;
	assign busy = (step_q != S_IDLE);

	always_comb begin
		step_next = step_q + 4'd1;
		case (word.cond)
			COND_NEXT: begin
				step_next = step_q + 4'd1;
			end
			COND_GOTO: begin
				step_next = word.target;
			end
			COND_X_LOOP: begin
				step_next = status.x_last ? (step_q + 4'd1) : word.target;
			end
			COND_DISPATCH: begin
				step_next = S_IDLE;
				if (start) begin
					case (action)
						ACT_SCHEDULE: begin
							step_next = S_SINIT;
						end
						ACT_GENERATE: begin
							step_next = status.keyed ? S_GEN1 : S_UNK;
						end
						default: begin
							step_next = S_IDLE;
						end
					endcase
				end
			end
			default: begin
				step_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> step_q == S_IDLE)
		else $error("result emitted from a step that does not return to idle");

	a_sched_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_SCHEDULE) |=> step_q == S_SINIT)
		else $error("schedule transfer did not enter the schedule program");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_LOAD) |=> step_q == S_IDLE)
		else $error("load transfer left the sequencer busy");

	a_gen_order: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == S_GEN6 |-> $past(step_q == S_GEN5))
		else $error("keystream output step reached out of order");

endmodule

`default_nettype wire

// ===== design/rc4kg_datapath.sv =====
// ----------------------------------------------------------------------------
// rc4kg_datapath
// Permutation and key stores, index registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4kg_datapath
	import rc4kg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_ctl_t    ctl,
	input  wire logic       key_we,
	input  wire logic [7:0] key_index,
	input  wire logic [7:0] key_byte,
	input  wire logic       len_we,
	input  wire logic [8:0] len_wdata,
	output dp_status_t      status,
	output logic            result_valid,
	output logic [1:0]      result_kind,
	output logic [7:0]      keystream_byte
);

	logic [7:0]        perm_mem [PERM_SIZE];
	logic [7:0]        key_mem  [MAX_KEY_BYTES];

	logic [7:0]        x_q;
	logic [KEY_AW-1:0] k_q;
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic [7:0]        sa_q;
	logic [7:0]        sb_q;
	logic [7:0]        s_rd_q;
	logic [7:0]        k_rd_q;
	logic              keyed_q;
	logic [8:0]        key_length_q;
	logic              result_valid_q;
	logic [1:0]        result_kind_q;
	logic [7:0]        keystream_byte_q;

	logic [7:0]        mem_addr;
	logic [7:0]        mem_wdata;
	logic [8:0]        key_len_eff;
	logic              k_last;
	logic              key_in_range;

	assign key_len_eff  = eff_key_len(key_length_q);
	assign k_last       = ((9'(k_q) + 9'd1) >= key_len_eff);
	assign key_in_range = ({1'b0, key_index} < 9'(MAX_KEY_BYTES));

	// keyed flag, then last permutation entry
	assign status = {keyed_q, (x_q == 8'hFF)};

	always_comb begin
		case (ctl.addr_sel)
			ADDR_X:     mem_addr = x_q;
			ADDR_KSA:   mem_addr = 8'(j_q + s_rd_q + k_rd_q);
			ADDR_J:     mem_addr = j_q;
			ADDR_I_INC: mem_addr = 8'(i_q + 8'd1);
			ADDR_J_SUM: mem_addr = 8'(j_q + s_rd_q);
			ADDR_AB:    mem_addr = 8'(sa_q + sb_q);
			ADDR_I:     mem_addr = i_q;
			default:    mem_addr = x_q;
		endcase
	end

	always_comb begin
		case (ctl.wd_sel)
			WD_X:    mem_wdata = x_q;
			WD_SRD:  mem_wdata = s_rd_q;
			WD_SA:   mem_wdata = sa_q;
			default: mem_wdata = x_q;
		endcase
	end

	// single-port permutation store, read data registered
	always_ff @(posedge clk) begin
		if (ctl.mem_op == MEM_WR) begin
			perm_mem[mem_addr] <= mem_wdata;
		end else if (ctl.mem_op == MEM_RD) begin
			s_rd_q <= perm_mem[mem_addr];
		end
	end

	// key store: load transfers write, the schedule reads at k every cycle
	always_ff @(posedge clk) begin
		if (key_we && key_in_range) begin
			key_mem[key_index[KEY_AW-1:0]] <= key_byte;
		end
		k_rd_q <= key_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.sa_ld) begin
			sa_q <= s_rd_q;
		end
		if (ctl.sb_ld) begin
			sb_q <= s_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q              <= '0;
			k_q              <= '0;
			i_q              <= '0;
			j_q              <= '0;
			keyed_q          <= 1'b0;
			key_length_q     <= KEY_LENGTH_RESET;
			result_valid_q   <= 1'b0;
			result_kind_q    <= KIND_SCHEDULED;
			keystream_byte_q <= '0;
		end else begin
			if (len_we) begin
				key_length_q <= len_wdata;
			end
			if (ctl.clr_idx) begin
				x_q <= '0;
				k_q <= '0;
				i_q <= '0;
				j_q <= '0;
			end else begin
				if (ctl.x_inc) begin
					x_q <= 8'(x_q + 8'd1);
				end
				if (ctl.k_inc) begin
					k_q <= k_last ? '0 : KEY_AW'(k_q + 1'b1);
				end
				if (ctl.i_ld) begin
					i_q <= mem_addr;
				end
				if (ctl.j_ld) begin
					j_q <= mem_addr;
				end
			end
			if (ctl.set_keyed) begin
				keyed_q <= 1'b1;
			end
			result_valid_q <= ctl.emit;
			if (ctl.emit) begin
				result_kind_q    <= ctl.kind;
				keystream_byte_q <= (ctl.kind == KIND_BYTE) ? s_rd_q : 8'd0;
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign result_kind    = result_kind_q;
	assign keystream_byte = keystream_byte_q;

endmodule

`default_nettype wire

// ===== design/rc4_keystream_generator_top.sv =====
// ----------------------------------------------------------------------------
// rc4_keystream_generator_top
// RC4 keystream engine: key load, key scheduling and keystream generation
// run by a microcoded sequencer over a single-port permutation store.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------
//  command   | start / busy         | action, key_index, key_byte
//  result    | result_valid strobe  | result_kind, keystream_byte
//  config    | key_length_we        | key_length
//
//  a command transfers on a clock edge with start high and busy low
//  load: written at the transfer edge, busy stays low, no result
//  generate over one permutation port: read S[i], read S[j], write both back swapped, read S[S[i]+S[j]], output
//  generate before keying: busy for the unkeyed result step only
//  schedule: clear, identity fill of 256 entries, a swap per entry (read, read, write, write), finish
//  the result strobe is high for one cycle right after busy falls; no stall
//  reset clears indices, keyed flag and key_length (16); stores are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_keystream_generator_top
	import rc4kg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] action,
	input  wire logic [7:0] key_index,
	input  wire logic [7:0] key_byte,
	input  wire logic       key_length_we,
	input  wire logic [8:0] key_length,
	output logic            result_valid,
	output logic [1:0]      result_kind,
	output logic [7:0]      keystream_byte
);

	dp_ctl_t    ctl;
	dp_status_t status;
	logic       load_xfer;

	assign load_xfer = start && !busy && (action == ACT_LOAD);

	rc4kg_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.ctl    (ctl),
		.busy   (busy)
	);

	rc4kg_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.key_we         (load_xfer),
		.key_index      (key_index),
		.key_byte       (key_byte),
		.len_we         (key_length_we),
		.len_wdata      (key_length),
		.status         (status),
		.result_valid   (result_valid),
		.result_kind    (result_kind),
		.keystream_byte (keystream_byte)
	);

endmodule

`default_nettype wire
